// ===== hw/rtl/brr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_pkg
// shared types and constants of the brr block decoder
// ----------------------------------------------------------------------------
package brr_pkg;

    // block layout: header at position 0, data bytes at 1..8
    localparam logic [3:0] BLOCK_POS_HEADER = 4'd0;
    localparam logic [3:0] BLOCK_POS_FIRST  = 4'd1;
    localparam logic [3:0] BLOCK_POS_LAST   = 4'd8;

    // shifts at or above this limit saturate the nibble
    localparam logic [3:0] SHIFT_LIMIT = 4'd13;

    // work queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // predictor filter codes from the header
    typedef enum logic [1:0] {
        FILT_NONE  = 2'd0,
        FILT_ONE   = 2'd1,
        FILT_TWO   = 2'd2,
        FILT_THREE = 2'd3
    } t_filter;

    // one data byte ready for decoding, with the header fields it needs
    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] shift;
        t_filter    filter;
        logic       loop_flag;
        logic       last_byte;   // final data byte of an end-flagged block
        logic       clear_hist;  // history starts from zero for this byte
    } t_work;

endpackage : brr_pkg
`default_nettype wire

// ===== hw/rtl/brr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_front
// accepts stream bytes, tracks block position and header, queues data bytes
// ----------------------------------------------------------------------------
module brr_front
    import brr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_new_sample,
    output logic            o_push,
    output t_work           o_work,
    input  wire logic       i_full
);

    logic [3:0] r_pos, n_pos;
    logic [3:0] r_shift, n_shift;
    t_filter    r_filter, n_filter;
    logic       r_loop, n_loop;
    logic       r_end, n_end;
    logic       r_done, n_done;
    logic       r_clr, n_clr;

    logic       accept;
    logic [3:0] eff_pos;
    logic       eff_done;
    logic       eff_clr;
    logic       at_last;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    // new_sample clears position and done flag before the byte is handled
    assign eff_pos  = i_new_sample ? BLOCK_POS_HEADER : r_pos;
    assign eff_done = i_new_sample ? 1'b0 : r_done;
    assign eff_clr  = i_new_sample || r_clr;
    assign at_last  = (eff_pos >= BLOCK_POS_LAST);

    always_comb begin
        n_pos    = r_pos;
        n_shift  = r_shift;
        n_filter = r_filter;
        n_loop   = r_loop;
        n_end    = r_end;
        n_done   = r_done;
        n_clr    = r_clr;
        o_push   = 1'b0;

        o_work.data_byte  = i_data_byte;
        o_work.shift      = r_shift;
        o_work.filter     = r_filter;
        o_work.loop_flag  = r_loop;
        o_work.last_byte  = at_last && r_end;
        o_work.clear_hist = eff_clr;

        if (accept) begin
            n_pos  = eff_pos;
            n_done = eff_done;
            n_clr  = eff_clr;
            if (!eff_done) begin
                if (eff_pos == BLOCK_POS_HEADER) begin
                    n_shift  = i_data_byte[7:4];
                    n_filter = t_filter'(i_data_byte[3:2]);
                    n_loop   = i_data_byte[1];
                    n_end    = i_data_byte[0];
                    n_pos    = BLOCK_POS_FIRST;
                end else begin
                    o_push = 1'b1;
                    n_clr  = 1'b0;
                    if (at_last) begin
                        n_pos = BLOCK_POS_HEADER;
                        if (r_end) begin
                            n_done = 1'b1;
                        end
                    end else begin
                        n_pos = eff_pos + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= BLOCK_POS_HEADER;
            r_shift  <= '0;
            r_filter <= FILT_NONE;
            r_loop   <= 1'b0;
            r_end    <= 1'b0;
            r_done   <= 1'b0;
            r_clr    <= 1'b1;   // history starts from zero after reset too
        end else begin
            r_pos    <= n_pos;
            r_shift  <= n_shift;
            r_filter <= n_filter;
            r_loop   <= n_loop;
            r_end    <= n_end;
            r_done   <= n_done;
            r_clr    <= n_clr;
        end
    end

endmodule : brr_front
`default_nettype wire

// ===== hw/rtl/brr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_queue
// short work queue between the front and the back
// ----------------------------------------------------------------------------
module brr_queue
    import brr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_work      i_work,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_work      o_work
);

    t_work                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic                   do_push;
    logic                   do_pop;

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule : brr_queue
`default_nettype wire

// ===== hw/rtl/brr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_back
// decodes two nibbles per queued byte through shift, filter and clamp
// ----------------------------------------------------------------------------
module brr_back
    import brr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  t_work                   i_work,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_pcm_sample,
    output logic                    o_last_sample,
    output logic                    o_loop_marked
);

    logic                r_phase;   // 0 high nibble, 1 low nibble
    logic signed [14:0]  r_newer;
    logic signed [14:0]  r_older;
    logic                r_out_valid;
    logic signed [15:0]  r_pcm;
    logic                r_last;
    logic                r_loop;

    logic                step;
    logic                use_zero;
    logic signed [14:0]  h_newer;
    logic signed [14:0]  h_older;
    logic [3:0]          nib;
    logic signed [16:0]  nib_ext;
    logic signed [16:0]  nib_shl;
    logic signed [16:0]  base;
    logic signed [18:0]  p_n15;
    logic signed [20:0]  p_n61;
    logic signed [21:0]  p_n115;
    logic signed [18:0]  p_o15;
    logic signed [18:0]  p_o13;
    logic signed [18:0]  s_n15;
    logic signed [20:0]  s_n61;
    logic signed [21:0]  s_n115;
    logic signed [18:0]  s_o15;
    logic signed [18:0]  s_o13;
    logic signed [17:0]  pred;
    logic signed [17:0]  sum;
    logic signed [15:0]  clamped;
    logic signed [14:0]  n_hist;

    assign step  = i_valid && (!r_out_valid || i_out_ready);
    assign o_pop = step && r_phase;

    // history restarts at zero for the first nibble after new_sample
    assign use_zero = i_work.clear_hist && !r_phase;
    assign h_newer  = use_zero ? '0 : r_newer;
    assign h_older  = use_zero ? '0 : r_older;

    assign nib     = r_phase ? i_work.data_byte[3:0] : i_work.data_byte[7:4];
    assign nib_ext = {{13{nib[3]}}, nib};
    assign nib_shl = nib_ext <<< i_work.shift;

    always_comb begin
        if (i_work.shift >= SHIFT_LIMIT) begin
            base = nib[3] ? -17'sd2048 : 17'sd0;
        end else begin
            base = nib_shl >>> 1;
        end
    end

    assign p_n15  = 19'(h_newer) * 19'sd15;
    assign p_n61  = 21'(h_newer) * 21'sd61;
    assign p_n115 = 22'(h_newer) * 22'sd115;
    assign p_o15  = 19'(h_older) * 19'sd15;
    assign p_o13  = 19'(h_older) * 19'sd13;

    assign s_n15  = p_n15 >>> 4;
    assign s_n61  = p_n61 >>> 5;
    assign s_n115 = p_n115 >>> 6;
    assign s_o15  = p_o15 >>> 4;
    assign s_o13  = p_o13 >>> 4;

    always_comb begin
        case (i_work.filter)
            FILT_NONE:  pred = '0;
            FILT_ONE:   pred = 18'(s_n15);
            FILT_TWO:   pred = 18'(s_n61) - 18'(s_o15);
            FILT_THREE: pred = 18'(s_n115) - 18'(s_o13);
            default:    pred = '0;
        endcase
    end

    assign sum = 18'(base) + pred;

    always_comb begin
        if (sum > 18'sd32767) begin
            clamped = 16'sd32767;
        end else if (sum < -18'sd32768) begin
            clamped = -16'sd32768;
        end else begin
            clamped = 16'(sum);
        end
    end

    assign n_hist = clamped[14:0];

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_newer <= n_hist;
            r_older <= h_newer;
            r_pcm   <= {n_hist, 1'b0};
            r_last  <= r_phase && i_work.last_byte;
            r_loop  <= i_work.loop_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase     <= !r_phase;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pcm_sample  = r_pcm;
    assign o_last_sample = r_last;
    assign o_loop_marked = r_loop;

endmodule : brr_back
`default_nettype wire

// ===== hw/rtl/brr_adpcm_block_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_adpcm_block_decoder
// brr adpcm stream decoder: 9-byte blocks in, 16-bit pcm samples out
// ----------------------------------------------------------------------------
// Takes one stream byte per input beat. A header byte gives no output;
// each data byte gives two output beats, high nibble first, and holds the
// decode datapath until both samples are out, one sample at a time, because
// each sample feeds the two-sample history that the next one is predicted
// from. The header is taken while a queued data byte is still decoding. A
// two-entry work queue sits between the byte parser and the sample datapath,
// and the output is held in a register, so the parser keeps taking bytes,
// until two data bytes are queued, while a sample waits on the output side.
// Raising new_sample with a byte makes that byte a header and zeroes
// history; history also starts at zero after reset. After the last byte of
// an end-flagged block, bytes without new_sample are consumed and dropped.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module brr_adpcm_block_decoder
    import brr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input stream
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_new_sample,
    // output samples
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_pcm_sample,
    output logic                    o_last_sample,
    output logic                    o_loop_marked
);

    // parser to queue
    logic  push;
    t_work push_work;
    logic  q_full;

    // queue to datapath
    logic  q_valid;
    t_work q_work;
    logic  q_pop;

    // parser: header capture, block position, end-of-stream drop
    brr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_new_sample (i_new_sample),
        .o_push       (push),
        .o_work       (push_work),
        .i_full       (q_full)
    );

    // decoupling queue, one entry per data byte
    brr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    // sample datapath with history and output register
    brr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_work        (q_work),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pcm_sample  (o_pcm_sample),
        .o_last_sample (o_last_sample),
        .o_loop_marked (o_loop_marked)
    );

endmodule : brr_adpcm_block_decoder
`default_nettype wire

// ===== hw/rtl/brr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_checker
// port-level checks of the brr block decoder
// ----------------------------------------------------------------------------
module brr_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_new_sample,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [15:0] o_pcm_sample,
    input  wire logic               o_last_sample,
    input  wire logic               o_loop_marked
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pcm_sample)
            && $stable(o_last_sample) && $stable(o_loop_marked))
        else $error("output beat changed while stalled");

    // samples are doubled 15-bit values
    a_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_pcm_sample[0])
        else $error("odd pcm sample");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a last-sample beat never repeats back to back once taken
    a_last_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_sample |=> !(o_out_valid && o_last_sample))
        else $error("last sample repeated");

endmodule : brr_checker

bind brr_adpcm_block_decoder brr_checker u_checker (.*);
`default_nettype wire
